// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_CLK_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_RST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/mlaes_pkg.sv =====
package mlaes_pkg;

  localparam int LaneW = 4;

  typedef enum logic [1:0] {
    REG_KEY_HI = 2'd0,
    REG_KEY_LO = 2'd1,
    REG_IV_HI  = 2'd2,
    REG_IV_LO  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LaneW-1:0] lane;
    logic             store;
    logic [127:0]     text;
    logic [127:0]     iv;
  } job_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = s[x];
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [127:0] round_fn(input logic [127:0] st, input logic [127:0] rk,
                                            input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = sbox(st[127-8*(r+4*((c+r)%4)) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[127-32*c -: 8];
      a1 = t[119-32*c -: 8];
      a2 = t[111-32*c -: 8];
      a3 = t[103-32*c -: 8];
      m[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    round_fn = (last ? t : m) ^ rk;
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

// ===== hw/rtl/mlaes_if.sv =====
interface mlaes_in_if;
  logic                         valid;
  logic                         ready;
  logic [mlaes_pkg::LaneW-1:0]  lane;
  logic                         first_block;
  logic [63:0]                  plain_hi;
  logic [63:0]                  plain_lo;
  modport source (output valid, lane, first_block, plain_hi, plain_lo, input ready);
  modport sink   (input valid, lane, first_block, plain_hi, plain_lo, output ready);
endinterface

interface mlaes_out_if;
  logic                         valid;
  logic                         ready;
  logic [mlaes_pkg::LaneW-1:0]  lane_out;
  logic [63:0]                  cipher_hi;
  logic [63:0]                  cipher_lo;
  modport source (output valid, lane_out, cipher_hi, cipher_lo, input ready);
  modport sink   (input valid, lane_out, cipher_hi, cipher_lo, output ready);
endinterface

// ===== hw/rtl/multi_lane_aes128_cbc_encrypt_core.sv =====
// Multi-lane AES-128 CBC encryptor.
// in_ch: lane, first_block, 128-bit plaintext beat; out_ch: lane_out and ciphertext.
// Configuration: cfg_we/cfg_idx/cfg_data write key_hi, key_lo, iv_hi, iv_lo while idle; the
// user must keep to this, as the core does not enforce it. Each block holds the shared round
// unit from its load through its last round (whitening folded into the load, then ten rounds
// with round keys computed on the fly); the next block loads in the cycle the last round
// finishes if the output register frees, so a new block starts only once the previous one is through.
// A two-entry queue sits in front of the round unit; the output register frees the
// unit unless a result is still held. A stalled receiver holds the output beat and,
// once the unit's next result is ready, stalls the unit and then the input.
// Reset (rst, synchronous) empties queue and pipeline and clears key and IV to zero;
// lane chaining values are undefined until that lane produces a block.
// A lane at or above LANES chains from the IV and stores no chaining value.
`include "assert_macros.svh"
module multi_lane_aes128_cbc_encrypt_core #(
  parameter int LANES = 9
) (
  input  logic        clk,
  input  logic        rst,
  mlaes_in_if.sink    in_ch,
  mlaes_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data
);
  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  logic job_valid, job_ready, job_chain;
  mlaes_pkg::job_t job;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
      iv_hi <= '0;
      iv_lo <= '0;
    end else if (cfg_we) begin
      case (mlaes_pkg::reg_idx_t'(cfg_idx))
        mlaes_pkg::REG_KEY_HI: key_hi <= cfg_data;
        mlaes_pkg::REG_KEY_LO: key_lo <= cfg_data;
        mlaes_pkg::REG_IV_HI:  iv_hi <= cfg_data;
        mlaes_pkg::REG_IV_LO:  iv_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  mlaes_front #(.LANES(LANES)) u_front (
    .clk, .rst, .in_ch, .iv({iv_hi, iv_lo}),
    .job_valid, .job_ready, .job, .job_chain
  );

  mlaes_back #(.LANES(LANES)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .job_chain,
    .key({key_hi, key_lo}), .out_ch
  );

  `ASSERT_CLK(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cipher_hi))
  `ASSERT_CLK(a_job_hold, clk, rst, job_valid && !job_ready |=> job_valid)
  `ASSERT_CLK_RST(a_rst_out, clk, rst |=> !out_ch.valid)
endmodule

// ===== hw/rtl/mlaes_front.sv =====
// Accepts beats and queues jobs. Chaining is resolved in the back end, since a lane's
// previous ciphertext may still be in flight.
module mlaes_front #(
  parameter int LANES = 9,
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  mlaes_in_if.sink          in_ch,
  input  logic [127:0]      iv,
  output logic              job_valid,
  input  logic              job_ready,
  output mlaes_pkg::job_t   job,
  output logic              job_chain
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mlaes_pkg::job_t q [DEPTH];
  logic            qc [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [PW:0]     cnt;
  logic            push, pop, in_range;

  assign in_ch.ready = (cnt != (PW+1)'(DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = job_valid && job_ready;
  assign job_valid = (cnt != '0);
  assign job = q[rp];
  assign job_chain = qc[rp];
  assign in_range = ({1'b0, in_ch.lane} < (mlaes_pkg::LaneW+1)'(LANES));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      q[wp].lane  <= in_ch.lane;
      q[wp].store <= in_range;
      q[wp].text  <= {in_ch.plain_hi, in_ch.plain_lo};
      q[wp].iv    <= iv;
      qc[wp]      <= in_range && !in_ch.first_block;
    end
  end
endmodule

// ===== hw/rtl/mlaes_back.sv =====
// One round per cycle: load (whitening) then 10 rounds, result into an output register.
module mlaes_back #(
  parameter int LANES = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  mlaes_pkg::job_t   job,
  input  logic              job_chain,
  input  logic [127:0]      key,
  mlaes_out_if.source       out_ch
);
  logic [127:0] chain [LANES];
  logic [127:0] st, rk, rk_next, kin, res;
  logic [7:0]   rcon;
  logic [3:0]   rnd;
  logic         busy, ovalid, store, start, done, fin;
  logic [mlaes_pkg::LaneW-1:0] lane, olane;
  logic [127:0] ores;

  assign done  = busy && (rnd == 4'd10);
  // last round result moves to the output slot this cycle
  assign fin   = done && (!ovalid || out_ch.ready);
  // next job may load in the cycle the last round finishes, if the output slot frees
  assign job_ready = (!busy || done) && (!ovalid || out_ch.ready || !done) && !(busy && !done);
  assign start = job_valid && job_ready;
  assign rk_next = mlaes_pkg::next_key(rk, rcon);
  assign res = mlaes_pkg::round_fn(st, rk_next, rnd == 4'd10);
  // chaining read after the write of a finishing job on the same lane
  assign kin = (job_chain ? (done && store && lane == job.lane ? res : chain[job.lane[$clog2(LANES > 1 ? LANES : 2)-1:0]])
                          : job.iv) ^ job.text;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      ovalid <= fin || (ovalid && !out_ch.ready);
      busy <= start || (busy && !fin);
    end
    if (fin) begin
      olane <= lane;
      ores <= res;
      if (store) chain[lane[$clog2(LANES > 1 ? LANES : 2)-1:0]] <= res;
    end
    if (start) begin
      st <= kin ^ key;
      rk <= key;
      rcon <= 8'h01;
      rnd <= 4'd1;
      lane <= job.lane;
      store <= job.store;
    end else if (busy && !done) begin
      st <= res;
      rk <= rk_next;
      rcon <= mlaes_pkg::xt(rcon);
      rnd <= rnd + 4'd1;
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.lane_out = olane;
  assign out_ch.cipher_hi = ores[127:64];
  assign out_ch.cipher_lo = ores[63:0];
endmodule
